// ===== rtl/cse_pkg.sv =====
// Shared constants, state codes and control/status types for the cosh series evaluator.
package cse_pkg;

  localparam int X_W       = 6;   // argument width, two's complement
  localparam int SUM_W     = 40;  // result width, unsigned fixed point
  localparam int CNT_W     = 7;   // terms_used width
  localparam int EPS_W     = 32;  // threshold width, Q16.16
  localparam int EPS_FRAC  = 16;  // fraction bits of the threshold
  localparam int MAG_W     = 6;   // |x| fits 0..32
  localparam int KSQ_W     = 11;  // x^2 fits 0..1024
  localparam int PROD_W    = SUM_W + KSQ_W;
  localparam int DIV_BITS  = 4;   // quotient bits retired per divider cycle
  localparam int DIV_W     = ((PROD_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
  localparam int DIV_CYC   = DIV_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);
  localparam int CMP_W     = SUM_W + EPS_FRAC;

  localparam int MAX_TERMS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(66);
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_ACC  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;   // capture argument, seed sum and term
    logic mul;    // form term * x^2 and the next denominator
    logic div;    // retire DIV_BITS quotient bits
    logic acc;    // add the new term and update count and flag
    logic emit;   // move the finished result into the output register
  } cmd_t;

  typedef struct packed {
    logic skip;      // threshold at or above one: no terms are summed
    logic div_last;  // divider retires its last bits this cycle
    logic stop;      // summing ends with the term being added
  } sts_t;

endpackage

// ===== rtl/cse_ctrl.sv =====
// Controller state machine: sequences load, multiply, divide, accumulate and emit.
module cse_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  cse_pkg::sts_t sts,
  output cse_pkg::cmd_t cmd
);
  import cse_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_take;
  logic   slot_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          cmd.load  = 1'b1;
          state_nxt = sts.skip ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.stop ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        // hold until the output register can take the word
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r != ST_IDLE)
    else $error("accepted word did not start processing");

  a_acc_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC |-> $past(state_r) == ST_DIV)
    else $error("accumulate entered without a finished division");

  a_emit_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted result not presented");

endmodule

// ===== rtl/cse_dpath.sv =====
// Datapath: threshold register, term multiply, radix-16 divider, sum and output register.
module cse_dpath #(
  parameter int MAX_TERMS = cse_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = cse_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [cse_pkg::EPS_W-1:0]     cfg_wr_data,
  input  logic signed [cse_pkg::X_W-1:0] in_x_value,
  input  cse_pkg::cmd_t                 cmd,
  output cse_pkg::sts_t                 sts,
  output logic [cse_pkg::SUM_W-1:0]     out_cosh_value,
  output logic [cse_pkg::CNT_W-1:0]     out_terms_used,
  output logic                          out_error_flag
);
  import cse_pkg::*;

  localparam int DEN_W = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS - 1) + 1);
  localparam int TWO_N_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_BITS;

  logic [EPS_W-1:0]     eps_r, eps_nxt;
  logic [KSQ_W-1:0]     ksq_r, ksq_nxt;
  logic [SUM_W-1:0]     term_r, term_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 err_r, err_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [DEN_W:0]       rem_r, rem_nxt;
  logic [DIV_W-1:0]     num_r, num_nxt;
  logic [DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [SUM_W-1:0]     osum_r, osum_nxt;
  logic [CNT_W-1:0]     ocnt_r, ocnt_nxt;
  logic                 oerr_r, oerr_nxt;

  logic [MAG_W-1:0]         mag;
  logic [PROD_W-1:0]        prod;
  logic [TWO_N_W-1:0]       two_n;
  logic [2*TWO_N_W-1:0]     den_full;
  logic [DEN_W:0]           rem_v;
  logic [DIV_W-1:0]         num_v;
  logic [DIV_W:0]           sum_ext;
  logic                     ovf, conv, cap;
  logic [CNT_W-1:0]         cnt_inc;
  logic [CMP_W-1:0]         term_cmp, eps_cmp;

  // |x| and the step operands
  assign mag      = in_x_value[X_W-1] ? MAG_W'(~in_x_value + 1'b1) : MAG_W'(in_x_value);
  assign prod     = PROD_W'(term_r) * PROD_W'(ksq_r);
  assign two_n    = {cnt_r + CNT_W'(1), 1'b0};
  assign den_full = (2*TWO_N_W)'(two_n) * (2*TWO_N_W)'(two_n - TWO_N_W'(1));

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    rem_v = rem_r;
    num_v = num_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_v = {rem_v[DEN_W-1:0], num_v[DIV_W-1]};
      num_v = {num_v[DIV_W-2:0], 1'b0};
      if (rem_v >= {1'b0, den_r}) begin
        rem_v    = rem_v - {1'b0, den_r};
        num_v[0] = 1'b1;
      end
    end
  end

  // accumulate checks on the finished quotient
  assign sum_ext  = (DIV_W+1)'(sum_r) + (DIV_W+1)'(num_r);
  assign ovf      = sum_ext > (DIV_W+1)'(SUM_MAX);
  assign term_cmp = CMP_W'(num_r[SUM_W-1:0]) << EPS_FRAC;
  assign eps_cmp  = CMP_W'(eps_r) << FRAC_BITS;
  assign conv     = term_cmp <= eps_cmp;
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign cap      = cnt_inc == CNT_W'(MAX_TERMS);

  assign sts.skip     = |eps_r[EPS_W-1:EPS_FRAC];
  assign sts.div_last = dcnt_r == '0;
  assign sts.stop     = ovf || conv || cap;

  always_comb begin
    eps_nxt  = cfg_wr_en ? cfg_wr_data : eps_r;
    ksq_nxt  = ksq_r;
    term_nxt = term_r;
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    err_nxt  = err_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    dcnt_nxt = dcnt_r;
    osum_nxt = osum_r;
    ocnt_nxt = ocnt_r;
    oerr_nxt = oerr_r;
    if (cmd.load) begin
      ksq_nxt  = KSQ_W'(mag) * KSQ_W'(mag);
      term_nxt = ONE;
      sum_nxt  = ONE;
      cnt_nxt  = '0;
      err_nxt  = 1'b0;
    end
    if (cmd.mul) begin
      num_nxt  = DIV_W'(prod);
      rem_nxt  = '0;
      den_nxt  = DEN_W'(den_full);
      dcnt_nxt = DIV_CNT_W'(DIV_CYC - 1);
    end
    if (cmd.div) begin
      num_nxt  = num_v;
      rem_nxt  = rem_v;
      dcnt_nxt = dcnt_r - DIV_CNT_W'(1);
    end
    if (cmd.acc) begin
      cnt_nxt  = cnt_inc;
      term_nxt = num_r[SUM_W-1:0];
      if (ovf) begin
        sum_nxt = SUM_MAX;
        err_nxt = 1'b1;
      end else begin
        sum_nxt = sum_ext[SUM_W-1:0];
        err_nxt = !conv && cap;
      end
    end
    if (cmd.emit) begin
      osum_nxt = sum_r;
      ocnt_nxt = cnt_r;
      oerr_nxt = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else begin
      eps_r <= eps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ksq_r  <= ksq_nxt;
    term_r <= term_nxt;
    sum_r  <= sum_nxt;
    cnt_r  <= cnt_nxt;
    err_r  <= err_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    dcnt_r <= dcnt_nxt;
    osum_r <= osum_nxt;
    ocnt_r <= ocnt_nxt;
    oerr_r <= oerr_nxt;
  end

  assign out_cosh_value = osum_r;
  assign out_terms_used = ocnt_r;
  assign out_error_flag = oerr_r;

  a_load_seeds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cnt_r == '0 && sum_r == ONE && !err_r)
    else $error("load did not seed the sum");

  a_cnt_capped: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc |-> cnt_r < CNT_W'(MAX_TERMS))
    else $error("term count ran past the cap");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc && ovf |=> sum_r == SUM_MAX && err_r)
    else $error("overflowing term did not saturate the sum");

endmodule

// ===== rtl/cosh_series_evaluator_unit.sv =====
// Top level of the cosh series evaluator: controller plus datapath.
//
// Usage:
//   Input channel in_valid / in_stall / in_x_value carries one signed 6-bit
//   argument per word; a word is taken at an edge with in_valid high and
//   in_stall low. The result channel out_valid / out_stall carries
//   out_cosh_value (unsigned Q24.16 by default, saturating), out_terms_used
//   and out_error_flag. cfg_wr_en / cfg_wr_data write the 32-bit Q16.16
//   convergence threshold; write it only while the block is idle.
// Timing:
//   One word at a time. Each series term runs one multiply step, then the
//   divide steps (the restoring divider retires 4 quotient bits per cycle
//   over a 52-bit dividend) and one accumulate step; a finished word
//   then passes through the done state into the output register, and
//   a threshold of one or more sends it from load straight to done.
//   in_stall is high from acceptance until the result moves to the output.
// Reset (rst_n low, synchronous): controller to idle, output empty,
//   threshold back to 66 (about 0.001).
// Stall: a finished result waits in the output register while the next
//   word is taken and processed; a second result holds in the datapath.
module cosh_series_evaluator_unit #(
  parameter int MAX_TERMS = cse_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = cse_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [cse_pkg::EPS_W-1:0]      cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [cse_pkg::X_W-1:0] in_x_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cse_pkg::SUM_W-1:0]      out_cosh_value,
  output logic [cse_pkg::CNT_W-1:0]      out_terms_used,
  output logic                           out_error_flag
);
  import cse_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: one state per phase of a term
  cse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic, threshold register and result register
  cse_dpath #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_x_value     (in_x_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_cosh_value (out_cosh_value),
    .out_terms_used (out_terms_used),
    .out_error_flag (out_error_flag)
  );

  // no terms summed means the threshold skipped the series: the result is one
  a_skip_is_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_terms_used == '0 |->
      out_cosh_value == (SUM_W'(1) << FRAC_BITS) && !out_error_flag)
    else $error("empty series did not give one");

  // an error below the cap can only be saturation
  a_err_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_flag && out_terms_used != CNT_W'(MAX_TERMS) |->
      out_cosh_value == SUM_MAX)
    else $error("error flag without saturation or cap");

  a_terms_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_terms_used <= CNT_W'(MAX_TERMS))
    else $error("terms_used above the cap");

endmodule

// ===== verif/cosh_result_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the cosh series evaluator: predicts every result word and compares it.
module cosh_result_checker #(
  parameter int MAX_TERMS = cse_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = cse_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [cse_pkg::EPS_W-1:0]      cfg_wr_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [cse_pkg::X_W-1:0] in_x_value,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [cse_pkg::SUM_W-1:0]      out_cosh_value,
  input  logic [cse_pkg::CNT_W-1:0]      out_terms_used,
  input  logic                           out_error_flag,
  output int                             mismatches,
  output int                             open_words
);
  import cse_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0] cosh;
    logic [CNT_W-1:0] terms;
    logic             flag;
  } cosh_word_t;

  cosh_word_t       expected_cosh_q[$];
  logic [EPS_W-1:0] threshold;

  initial begin
    mismatches = 0;
    open_words = 0;
    threshold  = EPS_RESET;
  end

  // Sum the series term by term; each term truncates toward zero.
  function automatic cosh_word_t cosh_series(input logic [X_W-1:0] x,
                                             input logic [EPS_W-1:0] eps);
    logic [63:0] mag, ksq, sum, term, eps_cmp, den, top;
    int          n;
    int          count;
    cosh_word_t  r;
    mag     = x[X_W-1] ? (64'd1 << X_W) - 64'(x) : 64'(x);
    ksq     = mag * mag;
    top     = 64'(SUM_MAX);
    eps_cmp = 64'(eps) << FRAC_BITS;
    sum     = 64'd1 << FRAC_BITS;
    term    = sum;
    count   = 0;
    r.flag  = 1'b0;
    if ((sum << EPS_FRAC) > eps_cmp) begin
      for (n = 1; n <= MAX_TERMS; n++) begin
        den  = 64'((2 * n - 1) * (2 * n));
        term = (term * ksq) / den;
        count++;
        if (term > top - sum) begin
          // saturate: the overflowing term still counts
          sum    = top;
          r.flag = 1'b1;
          break;
        end
        sum += term;
        if ((term << EPS_FRAC) <= eps_cmp) break;
        if (count == MAX_TERMS) begin
          r.flag = 1'b1;
          break;
        end
      end
    end
    r.cosh  = sum[SUM_W-1:0];
    r.terms = CNT_W'(count);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
  endtask

  always @(posedge clk) begin : watch
    cosh_word_t want;
    if (!rst_n) begin
      threshold = EPS_RESET;
      expected_cosh_q.delete();
    end else begin
      if (cfg_wr_en) threshold = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_cosh_q.size() == 0) begin
          report_mismatch("unrequested result word", 64'(out_cosh_value), 64'd0);
        end else begin
          want = expected_cosh_q.pop_front();
          if (out_cosh_value !== want.cosh)
            report_mismatch("cosh_value", 64'(out_cosh_value), 64'(want.cosh));
          if (out_terms_used !== want.terms)
            report_mismatch("terms_used", 64'(out_terms_used), 64'(want.terms));
          if (out_error_flag !== want.flag)
            report_mismatch("error_flag", 64'(out_error_flag), 64'(want.flag));
        end
      end
      if (in_valid && !in_stall)
        expected_cosh_q.push_back(cosh_series(in_x_value, threshold));
    end
    open_words = expected_cosh_q.size();
  end

endmodule

// ===== verif/cosh_series_evaluator_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the cosh series evaluator: reset, stimulus phases, stalls and verdict.
module cosh_series_evaluator_unit_test;
  import cse_pkg::*;

  // Slowest legal run is roughly 600 words of up to 64 terms each plus stalls;
  // allow several times that before calling it a hang.
  localparam int CYCLE_LIMIT = 3_000_000;
  // Long receiver hold-off: spans several full 64-term evaluations.
  localparam int HOLD_CYCLES = 4000;
  localparam int N_DIRECTED  = 16;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [EPS_W-1:0]       cfg_wr_data;
  logic                   in_valid;
  logic                   in_stall;
  logic signed [X_W-1:0]  in_x_value;
  logic                   out_valid;
  logic                   out_stall;
  logic [SUM_W-1:0]       out_cosh_value;
  logic [CNT_W-1:0]       out_terms_used;
  logic                   out_error_flag;

  int   mismatches;
  int   open_words;
  int   cycles = 0;
  int   idle_pct = 0;   // chance in 100 that the sender skips a cycle
  int   stall_pct = 0;  // chance in 100 that the receiver stalls a cycle
  logic hold_req = 1'b0;

  // Edge arguments: zero, unit, the nominal limits, the first saturating
  // magnitudes and both ends of the 6-bit range (every bit toggles).
  int directed_x [N_DIRECTED] = '{0, 1, -1, 2, -2, 7, -9, 15, 16, -16, 17, -17, 18, 31,
                                  -32, 24};

  cosh_series_evaluator_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_x_value    (in_x_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cosh_value(out_cosh_value),
    .out_terms_used(out_terms_used),
    .out_error_flag(out_error_flag)
  );

  cosh_result_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_x_value    (in_x_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cosh_value(out_cosh_value),
    .out_terms_used(out_terms_used),
    .out_error_flag(out_error_flag),
    .mismatches    (mismatches),
    .open_words    (open_words)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off for a long stretch on request so
  // the output register and the datapath both fill and in_stall rises.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one word; hold it steady until the block takes it.
  task automatic send_word(input logic [X_W-1:0] x);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_x_value <= x;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result word has come back.
  task automatic drain_results;
    in_valid <= 1'b0;
    do @(negedge clk); while (open_words != 0);
  endtask

  // Write the threshold while the block is idle.
  task automatic write_threshold(input logic [EPS_W-1:0] eps);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= eps;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly the nominal -16..16 range; now and then anything the 6 bits allow.
  function automatic logic [X_W-1:0] draw_x;
    int v;
    if ($urandom_range(9) == 0) begin
      v = int'($urandom_range(63));
    end else begin
      v = int'($urandom_range(32)) - 16;
    end
    return X_W'(v);
  endfunction

  task automatic random_batch(input int n_words, input int idle, input int stall);
    int i;
    idle_pct  = idle;
    stall_pct = stall;
    for (i = 0; i < n_words; i++) send_word(draw_x());
    drain_results();
  endtask

  initial begin : stimulus
    int i;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_x_value  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words at the reset threshold, no idling.
    for (i = 0; i < N_DIRECTED; i++) send_word(X_W'(directed_x[i]));
    drain_results();

    // Zero threshold: sum until the truncated term reaches zero.
    write_threshold('0);
    random_batch(60, 0, 0);

    // Largest threshold, then exactly one: no terms summed at all.
    write_threshold('1);
    random_batch(40, 73, 0);
    write_threshold(EPS_W'(32'h0001_0000));
    random_batch(30, 0, 73);

    // Just below one: a single term converges only for |x| of one or less.
    write_threshold(EPS_W'(32'h0000_FFFF));
    random_batch(60, 18, 18);

    // A small random threshold, then any 32-bit value.
    write_threshold(EPS_W'($urandom_range(200)));
    random_batch(100, 73, 0);
    write_threshold(EPS_W'($urandom));
    random_batch(60, 0, 73);

    // Back to the reset value; hold the receiver off while the sender keeps
    // offering, so the block backs up and stalls its input.
    write_threshold(EPS_RESET);
    hold_req = 1'b1;
    random_batch(30, 0, 0);

    // Finest nonzero threshold, then a last random one with no idling.
    write_threshold(EPS_W'(1));
    random_batch(100, 18, 18);
    write_threshold(EPS_W'($urandom_range(4000)));
    random_batch(100, 0, 0);

    // Let any stray result word show up before the verdict.
    repeat (40) @(negedge clk);
    if (mismatches == 0 && open_words == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cse_pkg.sv
rtl/cse_ctrl.sv
rtl/cse_dpath.sv
rtl/cosh_series_evaluator_unit.sv
verif/cosh_result_checker.sv
verif/cosh_series_evaluator_unit_test.sv
